@@ rtl/assert_macros.svh @@
// Assertion helpers used by event_schedule_sort_delta.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ESD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ESD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/esd_pkg.sv @@
package esd_pkg;

  // Events per set and kept delay width.
  localparam int unsigned EVENT_COUNT = 8;
  localparam int unsigned DELAY_BITS  = 16;

  // Field widths fixed by the channel format.
  localparam int unsigned IN_DELAY_W = 16;
  localparam int unsigned PORT_W     = 6;
  localparam int unsigned WIDE_W     = 32;

  // Counter wide enough to hold EVENT_COUNT itself.
  localparam int unsigned CNT_W = $clog2(EVENT_COUNT + 1);

  // One stored event.
  typedef struct packed {
    logic [DELAY_BITS-1:0] delay;
    logic [PORT_W-1:0]     port;
    logic                  level;
  } event_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic insert;  // place the incoming event in sorted position
    logic shift;   // move every entry one cell toward the head
  } cell_ctrl_t;

endpackage

@@ rtl/esd_if.sv @@
// Input channel: one pulse event per transaction.
interface esd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] absolute_delay;
  logic [5:0]  port_number;
  logic        pin_level;

  modport source (output valid, absolute_delay, port_number, pin_level, input ready);
  modport sink   (input valid, absolute_delay, port_number, pin_level, output ready);
endinterface

// Output channel: one delta-encoded event per transaction.
interface esd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] relative_delay;
  logic [5:0]  out_port;
  logic        out_level;
  logic        last_event;

  modport source (output valid, relative_delay, out_port, out_level, last_event,
                  input ready);
  modport sink   (input valid, relative_delay, out_port, out_level, last_event,
                  output ready);
endinterface

@@ rtl/esd_cell.sv @@
// One slot of the sorted register chain.
module esd_cell (
  input  logic                clk_i,
  input  esd_pkg::cell_ctrl_t ctrl_i,
  input  logic                occupied_i,   // slot holds an event of this set
  input  esd_pkg::event_t     new_event_i,  // broadcast incoming event
  input  esd_pkg::event_t     left_event_i, // neighbor toward the tail's head side
  input  logic                left_gt_i,    // neighbor also yields to the new event
  input  esd_pkg::event_t     right_event_i,
  output esd_pkg::event_t     event_o,
  output logic                gt_o
);

  esd_pkg::event_t entry_q, entry_d;

  // Empty slots act as +infinity; strict compare keeps equal delays in load order.
  assign gt_o = !occupied_i || (entry_q.delay > new_event_i.delay);

  // Insert: take the new event at the boundary, else the left neighbor's; shift: take the right neighbor's.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert && gt_o) begin
      entry_d = left_gt_i ? left_event_i : new_event_i;
    end else if (ctrl_i.shift) begin
      entry_d = right_event_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign event_o = entry_q;

endmodule

@@ rtl/event_schedule_sort_delta.sv @@
// Channel  | Dir | Payload                                          | Transaction
// ---------+-----+--------------------------------------------------+--------------
// in_i     | in  | absolute_delay[15:0] port_number[5:0] pin_level  | valid & ready
// out_o    | out | relative_delay[15:0] out_port[5:0] out_level,    | valid & ready
//          |     | last_event                                       |
//
// While loading, each event drops into its sorted slot of
// the cell chain in the cycle it is accepted (one broadcast compare per cell).
// After the last event of a set, EVENT_COUNT results leave the chain head, one
// per cycle when out_o.ready is high; input is held off while the set drains.
// Reset clears the fill counter and state; cell contents stay undefined.
// A stall on out_o freezes the chain; results are neither lost nor repeated.
`include "assert_macros.svh"

module event_schedule_sort_delta (
  input  logic            clk_i,
  input  logic            rst_ni,
  esd_in_if.sink          in_i,
  esd_out_if.source       out_o
);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  localparam int unsigned N = esd_pkg::EVENT_COUNT;

  logic                          state_q, state_d;
  logic [esd_pkg::CNT_W-1:0]     count_q, count_d;
  logic [esd_pkg::DELAY_BITS-1:0] prev_q, prev_d;

  esd_pkg::cell_ctrl_t           ctrl;
  esd_pkg::event_t               new_event;
  esd_pkg::event_t               cell_event [N];
  logic                          cell_gt    [N];
  logic [esd_pkg::WIDE_W-1:0]    in_wide;
  logic [esd_pkg::WIDE_W-1:0]    rel_wide;
  logic [esd_pkg::DELAY_BITS-1:0] rel_delay;
  logic                          in_fire, out_fire;

  // Handshakes
  assign in_i.ready  = (state_q == ST_LOAD);
  assign out_o.valid = (state_q == ST_DRAIN);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_fire    = out_o.valid && out_o.ready;

  // Incoming event, delay kept to DELAY_BITS
  assign in_wide         = esd_pkg::WIDE_W'(in_i.absolute_delay);
  assign new_event.delay = in_wide[esd_pkg::DELAY_BITS-1:0];
  assign new_event.port  = in_i.port_number;
  assign new_event.level = in_i.pin_level;

  assign ctrl.insert = in_fire;
  assign ctrl.shift  = out_fire;

  // Sorted chain of cells, head at index 0
  for (genvar i = 0; i < N; i++) begin : g_cell
    esd_pkg::event_t left_ev, right_ev;
    logic            left_gt;
    logic            occupied;

    assign occupied = (esd_pkg::CNT_W'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_ev = new_event;
      assign left_gt = 1'b0;
    end else begin : g_body
      assign left_ev = cell_event[i-1];
      assign left_gt = cell_gt[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right_ev = cell_event[i];
    end else begin : g_inner
      assign right_ev = cell_event[i+1];
    end

    esd_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .occupied_i    (occupied),
      .new_event_i   (new_event),
      .left_event_i  (left_ev),
      .left_gt_i     (left_gt),
      .right_event_i (right_ev),
      .event_o       (cell_event[i]),
      .gt_o          (cell_gt[i])
    );
  end

  // Delta encoding at the chain head
  assign rel_delay            = cell_event[0].delay - prev_q;
  assign rel_wide             = esd_pkg::WIDE_W'(rel_delay);
  assign out_o.relative_delay = rel_wide[esd_pkg::IN_DELAY_W-1:0];
  assign out_o.out_port       = cell_event[0].port;
  assign out_o.out_level      = cell_event[0].level;
  assign out_o.last_event     = (count_q == esd_pkg::CNT_W'(1));

  // Load counts up, drain counts back down to zero
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    prev_d  = prev_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_fire) begin
          count_d = count_q + esd_pkg::CNT_W'(1);
          if (count_q == esd_pkg::CNT_W'(N - 1)) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_fire) begin
          count_d = count_q - esd_pkg::CNT_W'(1);
          prev_d  = cell_event[0].delay;
          if (count_q == esd_pkg::CNT_W'(1)) begin
            state_d = ST_LOAD;
            prev_d  = '0;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      prev_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      prev_q  <= prev_d;
    end
  end

  // Checks
  `ESD_ASSERT_NOW(a_no_overlap, 1'b1, !(in_i.ready && out_o.valid))
  `ESD_ASSERT_NOW(a_head_sorted, out_o.valid, cell_event[0].delay >= prev_q)
  `ESD_ASSERT_NEXT(a_full_drains, in_fire && count_q == esd_pkg::CNT_W'(N - 1), out_o.valid)
  `ESD_ASSERT_NEXT(a_last_reloads, out_fire && out_o.last_event,
                   in_i.ready && count_q == '0 && prev_q == '0)

endmodule
